// ----- src/variable_length_record_stack_assert.svh -----
// Assertion macros for the record stack checker.
// VLRS_ASSERT_NOW checks a consequent in the same cycle as its antecedent.
// VLRS_ASSERT_NEXT checks a consequent in the cycle after its antecedent.
`ifndef VARIABLE_LENGTH_RECORD_STACK_ASSERT_SVH
`define VARIABLE_LENGTH_RECORD_STACK_ASSERT_SVH

`define VLRS_ASSERT_NOW(lbl, clk_s, rstn_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |-> (cons)) \
		else $error(msg);

`define VLRS_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/vlrs_pkg.sv -----
// ----------------------------------------------------------------------------
// vlrs_pkg
// Shared constants, codes and controller/datapath interface types for the
// variable-length record stack.
// ----------------------------------------------------------------------------
`default_nettype none

package vlrs_pkg;

	localparam int CAPACITY     = 1024;
	localparam int HEADER_BYTES = 4;
	localparam int MAX_RECORD   = 64;

	localparam int ADDR_W = $clog2(CAPACITY);
	localparam int PTR_W  = $clog2(CAPACITY + 1);
	localparam int EXT_W  = PTR_W + 1;
	localparam int LEN_W  = 7;
	localparam int DATA_W = 8;
	localparam int HCNT_W = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES) : 1;

	localparam logic [PTR_W-1:0]  CAP_P    = PTR_W'(CAPACITY);
	localparam logic [PTR_W-1:0]  HDR_P    = PTR_W'(HEADER_BYTES);
	localparam logic [LEN_W-1:0]  MAX_P    = LEN_W'(MAX_RECORD);
	localparam logic [HCNT_W-1:0] HLAST_P  = HCNT_W'(HEADER_BYTES - 1);

	typedef enum logic [1:0] {
		FUNC_PUSH  = 2'd0,
		FUNC_POP   = 2'd1,
		FUNC_PEEK  = 2'd2,
		FUNC_CLEAR = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		ST_PUSHED  = 3'd0,
		ST_FULL    = 3'd1,
		ST_POPPED  = 3'd2,
		ST_PEEKED  = 3'd3,
		ST_EMPTY   = 3'd4,
		ST_CLEARED = 3'd5
	} status_t;

	// Commands from the controller, one per datapath step.
	typedef struct packed {
		logic take;      // capture the input transaction
		logic decode;    // first step of an item
		logic hdr_wr;    // write one header byte
		logic data_wr;   // finish a reservation, store first data byte
		logic hdr_rd;    // read one header byte
		logic calc;      // clamp the stored length
		logic commit;    // set byte count, free the record on pop
		logic byte_rd;   // read one record byte
		logic byte_out;  // present one record byte
		logic resp;      // present a single answer
	} ctl_cmd_t;

	// Status from the datapath back to the controller.
	typedef struct packed {
		func_t func;
		logic  first_push;
		logic  fits;
		logic  empty;
		logic  hdr_last;
		logic  cnt_zero;
		logic  byte_last;
		logic  out_free;
	} dp_stat_t;

endpackage

`default_nettype wire

// ----- src/vlrs_ctrl.sv -----
// ----------------------------------------------------------------------------
// vlrs_ctrl
// Sequencer for the record stack: steps each transaction through decode,
// header access and byte streaming, issuing one command set per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module vlrs_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire vlrs_pkg::dp_stat_t stat,
	output vlrs_pkg::ctl_cmd_t     cmd
);
	import vlrs_pkg::*;

	typedef enum logic [10:0] {
		S_IDLE     = 11'b000_0000_0001,
		S_DECODE   = 11'b000_0000_0010,
		S_HDR_WR   = 11'b000_0000_0100,
		S_DATA_WR  = 11'b000_0000_1000,
		S_HDR_RD   = 11'b000_0001_0000,
		S_HDR_END  = 11'b000_0010_0000,
		S_CALC     = 11'b000_0100_0000,
		S_COMMIT   = 11'b000_1000_0000,
		S_BYTE_RD  = 11'b001_0000_0000,
		S_BYTE_OUT = 11'b010_0000_0000,
		S_RESP     = 11'b100_0000_0000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				cmd.decode = 1'b1;
				case (stat.func)
					FUNC_PUSH:  state_d = (stat.first_push && stat.fits) ? S_HDR_WR : S_RESP;
					FUNC_CLEAR: state_d = S_RESP;
					default:    state_d = stat.empty ? S_RESP : S_HDR_RD;
				endcase
			end
			S_HDR_WR: begin
				cmd.hdr_wr = 1'b1;
				if (stat.hdr_last) begin
					state_d = S_DATA_WR;
				end
			end
			S_DATA_WR: begin
				cmd.data_wr = 1'b1;
				state_d     = S_RESP;
			end
			S_HDR_RD: begin
				cmd.hdr_rd = 1'b1;
				if (stat.hdr_last) begin
					state_d = S_HDR_END;
				end
			end
			S_HDR_END: begin
				state_d = S_CALC;
			end
			S_CALC: begin
				cmd.calc = 1'b1;
				state_d  = S_COMMIT;
			end
			S_COMMIT: begin
				cmd.commit = 1'b1;
				state_d    = stat.cnt_zero ? S_RESP : S_BYTE_RD;
			end
			S_BYTE_RD: begin
				cmd.byte_rd = 1'b1;
				state_d     = S_BYTE_OUT;
			end
			S_BYTE_OUT: begin
				if (stat.out_free) begin
					cmd.byte_out = 1'b1;
					state_d      = stat.byte_last ? S_IDLE : S_BYTE_RD;
				end
			end
			S_RESP: begin
				if (stat.out_free) begin
					cmd.resp = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

// ----- src/vlrs_dp.sv -----
// ----------------------------------------------------------------------------
// vlrs_dp
// Datapath of the record stack: byte memory, top pointer, push run state,
// header assembly, length clamping and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module vlrs_dp (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire vlrs_pkg::ctl_cmd_t                cmd,
	output vlrs_pkg::dp_stat_t                     stat,
	input  wire logic [1:0]                        func,
	input  wire logic [vlrs_pkg::LEN_W-1:0]        length,
	input  wire logic [vlrs_pkg::DATA_W-1:0]       data_byte,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic [2:0]                             status,
	output logic [vlrs_pkg::DATA_W-1:0]            out_byte,
	output logic                                   byte_valid,
	output logic                                   last,
	output logic                                   is_empty,
	output logic [vlrs_pkg::PTR_W-1:0]             free_bytes
);
	import vlrs_pkg::*;

	// Captured transaction
	func_t               func_q;
	logic [LEN_W-1:0]    length_q;
	logic [DATA_W-1:0]   data_q;

	// Stack control state
	logic [PTR_W-1:0]    top_q;
	logic [LEN_W-1:0]    push_rem_q;
	logic                push_rej_q;
	logic [PTR_W-1:0]    write_idx_q;
	logic [HCNT_W-1:0]   hcnt_q;

	// Pop/peek working registers
	logic [LEN_W-1:0]    hdr_lo_q;
	logic                hdr_big_q;
	logic [LEN_W-1:0]    stored_q;
	logic [LEN_W-1:0]    cnt_q;
	logic [EXT_W-1:0]    rd_addr_q;
	status_t             status_q;

	// Memory and read stage
	logic [DATA_W-1:0]   stack_mem_q [CAPACITY];
	logic [DATA_W-1:0]   rdata_s1;
	logic                rd_oob_s1;
	logic                hdr_pend_s1;
	logic [HCNT_W-1:0]   rd_tag_s1;

	// Output register
	logic                out_valid_q;
	status_t             out_status_q;
	logic [DATA_W-1:0]   out_byte_q;
	logic                out_bval_q;
	logic                out_last_q;
	logic                out_empty_q;
	logic [PTR_W-1:0]    out_free_q;

	logic [LEN_W-1:0]    lc_c;
	logic [PTR_W-1:0]    need_c;
	logic                first_c;
	logic                fits_c;
	logic                empty_c;
	logic [PTR_W-1:0]    room_c;
	logic [PTR_W-1:0]    avail_c;
	logic [LEN_W-1:0]    stored_raw_c;
	logic [LEN_W-1:0]    count_c;
	logic [PTR_W-1:0]    step_c;
	logic [DATA_W-1:0]   rbyte_c;
	logic                out_load_c;

	logic                we_c;
	logic [EXT_W-1:0]    waddr_c;
	logic [DATA_W-1:0]   wdata_c;
	logic                re_c;
	logic [EXT_W-1:0]    raddr_c;

	assign lc_c    = (length_q > MAX_P) ? MAX_P : length_q;
	assign need_c  = PTR_W'(lc_c) + HDR_P;
	assign first_c = (push_rem_q == '0);
	assign fits_c  = (top_q >= need_c);
	assign empty_c = (top_q == CAP_P);

	assign room_c       = CAP_P - top_q;
	assign avail_c      = (room_c > HDR_P) ? (room_c - HDR_P) : '0;
	assign stored_raw_c = hdr_big_q ? MAX_P : hdr_lo_q;
	assign count_c      = (length_q < stored_q) ? length_q : stored_q;
	assign step_c       = HDR_P + PTR_W'(stored_q);

	assign rbyte_c    = rd_oob_s1 ? '0 : rdata_s1;
	assign out_load_c = cmd.resp || cmd.byte_out;

	assign stat.func       = func_q;
	assign stat.first_push = first_c;
	assign stat.fits       = fits_c;
	assign stat.empty      = empty_c;
	assign stat.hdr_last   = (hcnt_q == HLAST_P);
	assign stat.cnt_zero   = (count_c == '0);
	assign stat.byte_last  = (cnt_q == LEN_W'(1));
	assign stat.out_free   = !out_valid_q || out_ready;

	// Write port: continuing push byte, header byte, or first data byte
	always_comb begin
		we_c    = 1'b0;
		waddr_c = '0;
		wdata_c = '0;
		if (cmd.decode && func_q == FUNC_PUSH && !first_c && !push_rej_q) begin
			we_c    = 1'b1;
			waddr_c = EXT_W'(write_idx_q);
			wdata_c = data_q;
		end else if (cmd.hdr_wr) begin
			we_c    = 1'b1;
			waddr_c = EXT_W'(top_q) + EXT_W'(hcnt_q);
			wdata_c = (hcnt_q == '0) ? DATA_W'(lc_c) : '0;
		end else if (cmd.data_wr && lc_c != '0) begin
			we_c    = 1'b1;
			waddr_c = EXT_W'(top_q) + EXT_W'(HDR_P);
			wdata_c = data_q;
		end
	end

	always_comb begin
		re_c    = cmd.hdr_rd || cmd.byte_rd;
		raddr_c = cmd.hdr_rd ? (EXT_W'(top_q) + EXT_W'(hcnt_q)) : rd_addr_q;
	end

	always_ff @(posedge clk) begin
		if (we_c && waddr_c < EXT_W'(CAPACITY)) begin
			stack_mem_q[waddr_c[ADDR_W-1:0]] <= wdata_c;
		end
		if (re_c) begin
			rdata_s1  <= stack_mem_q[raddr_c[ADDR_W-1:0]];
			rd_oob_s1 <= (raddr_c >= EXT_W'(CAPACITY));
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q       <= CAP_P;
			push_rem_q  <= '0;
			push_rej_q  <= 1'b0;
			write_idx_q <= '0;
			hcnt_q      <= '0;
			hdr_pend_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			hdr_pend_s1 <= cmd.hdr_rd;
			if (cmd.decode) begin
				case (func_q)
					FUNC_PUSH: begin
						if (!first_c) begin
							push_rem_q <= push_rem_q - LEN_W'(1);
							if (push_rej_q) begin
								if (push_rem_q == LEN_W'(1)) begin
									push_rej_q <= 1'b0;
								end
							end else begin
								write_idx_q <= write_idx_q + PTR_W'(1);
							end
						end else if (!fits_c) begin
							push_rej_q <= (lc_c > LEN_W'(1));
							push_rem_q <= (lc_c > LEN_W'(1)) ? (lc_c - LEN_W'(1)) : '0;
						end else begin
							top_q  <= top_q - need_c;
							hcnt_q <= '0;
						end
					end
					FUNC_CLEAR: begin
						push_rem_q <= '0;
						push_rej_q <= 1'b0;
						top_q      <= CAP_P;
					end
					default: begin
						push_rem_q <= '0;
						push_rej_q <= 1'b0;
						hcnt_q     <= '0;
					end
				endcase
			end
			if (cmd.hdr_wr || cmd.hdr_rd) begin
				hcnt_q <= hcnt_q + HCNT_W'(1);
			end
			if (cmd.data_wr) begin
				write_idx_q <= top_q + HDR_P + PTR_W'(lc_c != '0);
				push_rej_q  <= 1'b0;
				push_rem_q  <= (lc_c == '0) ? '0 : (lc_c - LEN_W'(1));
			end
			if (cmd.commit && func_q == FUNC_POP) begin
				top_q <= top_q + ((step_c < room_c) ? step_c : room_c);
			end
			if (out_load_c) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			func_q   <= func_t'(func);
			length_q <= length;
			data_q   <= data_byte;
		end
		if (cmd.decode) begin
			hdr_lo_q  <= '0;
			hdr_big_q <= 1'b0;
			case (func_q)
				FUNC_PUSH: begin
					if (!first_c) begin
						status_q <= push_rej_q ? ST_FULL : ST_PUSHED;
					end else begin
						status_q <= fits_c ? ST_PUSHED : ST_FULL;
					end
				end
				FUNC_CLEAR: status_q <= ST_CLEARED;
				FUNC_POP:   status_q <= empty_c ? ST_EMPTY : ST_POPPED;
				default:    status_q <= empty_c ? ST_EMPTY : ST_PEEKED;
			endcase
		end
		if (cmd.hdr_rd) begin
			rd_tag_s1 <= hcnt_q;
		end
		// Assemble the header, flag any value above the record cap
		if (hdr_pend_s1) begin
			if (rd_tag_s1 == '0) begin
				hdr_lo_q  <= rbyte_c[LEN_W-1:0];
				hdr_big_q <= hdr_big_q || (rbyte_c > DATA_W'(MAX_RECORD));
			end else begin
				hdr_big_q <= hdr_big_q || (rbyte_c != '0);
			end
		end
		if (cmd.calc) begin
			stored_q  <= (PTR_W'(stored_raw_c) < avail_c) ? stored_raw_c : LEN_W'(avail_c);
			rd_addr_q <= EXT_W'(top_q) + EXT_W'(HDR_P);
		end
		if (cmd.commit) begin
			cnt_q <= count_c;
		end
		if (cmd.byte_rd) begin
			rd_addr_q <= rd_addr_q + EXT_W'(1);
		end
		if (cmd.byte_out) begin
			cnt_q <= cnt_q - LEN_W'(1);
		end
		if (out_load_c) begin
			out_status_q <= status_q;
			out_byte_q   <= cmd.byte_out ? rbyte_c : '0;
			out_bval_q   <= cmd.byte_out;
			out_last_q   <= cmd.resp || (cnt_q == LEN_W'(1));
			out_empty_q  <= empty_c;
			out_free_q   <= top_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = out_status_q;
	assign out_byte   = out_byte_q;
	assign byte_valid = out_bval_q;
	assign last       = out_last_q;
	assign is_empty   = out_empty_q;
	assign free_bytes = out_free_q;

endmodule

`default_nettype wire

// ----- src/variable_length_record_stack.sv -----
// ----------------------------------------------------------------------------
// variable_length_record_stack
// Byte-store stack of variable-length records with push, pop, peek and clear.
//
// The stack lives in a 1024-byte single-port memory and grows downward from
// the top of the store. A record takes a 4-byte little-endian length header
// plus its data bytes (at most 64). Push is a run of byte transactions that
// all carry the record length; the first one checks space, reserves the
// record and writes the header, and a run that does not fit answers full on
// every one of its transactions. Pop and peek return min(stored, requested)
// bytes, one result per byte with last on the final one; pop also frees the
// record. Every result reports is_empty and free_bytes after the step. The
// block works on one transaction at a time, and a finished result waits in
// the output register while the next transaction is taken. The pace of a
// transaction is set by the single memory port, one header byte per cycle,
// and the registered read ahead of each streamed byte. The memory needs no
// clearing pass: the stack only reads bytes it has written.
// ----------------------------------------------------------------------------
`default_nettype none

module variable_length_record_stack (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [1:0]                        func,
	input  wire logic [vlrs_pkg::LEN_W-1:0]        length,
	input  wire logic [vlrs_pkg::DATA_W-1:0]       data_byte,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic [2:0]                             status,
	output logic [vlrs_pkg::DATA_W-1:0]            out_byte,
	output logic                                   byte_valid,
	output logic                                   last,
	output logic                                   is_empty,
	output logic [vlrs_pkg::PTR_W-1:0]             free_bytes
);
	import vlrs_pkg::*;

	// Commands down, status up: the only link between the two halves
	ctl_cmd_t cmd;
	dp_stat_t stat;

	// Sequencer: one state per step of a transaction
	vlrs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Datapath: memory, pointers, run state and the output register
	vlrs_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.func       (func),
		.length     (length),
		.data_byte  (data_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.out_byte   (out_byte),
		.byte_valid (byte_valid),
		.last       (last),
		.is_empty   (is_empty),
		.free_bytes (free_bytes)
	);

endmodule

`default_nettype wire

// ----- src/vlrs_checker.sv -----
// ----------------------------------------------------------------------------
// vlrs_checker
// Port-level checks on the record stack results, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "variable_length_record_stack_assert.svh"

module vlrs_checker (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              out_valid,
	input wire logic                              out_ready,
	input wire logic [2:0]                        status,
	input wire logic [vlrs_pkg::DATA_W-1:0]       out_byte,
	input wire logic                              byte_valid,
	input wire logic                              last,
	input wire logic                              is_empty,
	input wire logic [vlrs_pkg::PTR_W-1:0]        free_bytes
);
	import vlrs_pkg::*;

	// Hold a stalled result
	`VLRS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(status) && $stable(out_byte) && $stable(last)
		&& $stable(free_bytes), "stalled result changed")

	// Empty flag agrees with the free byte count
	`VLRS_ASSERT_NOW(a_empty_free, clk, arst_n, out_valid,
		is_empty == (free_bytes == CAP_P), "is_empty disagrees with free_bytes")

	// Record bytes come only from pop or peek
	`VLRS_ASSERT_NOW(a_byte_src, clk, arst_n, out_valid && byte_valid,
		status == ST_POPPED || status == ST_PEEKED, "record byte with wrong status")

	// Answers without a byte end their transaction
	`VLRS_ASSERT_NOW(a_single_last, clk, arst_n, out_valid && !byte_valid,
		last && out_byte == '0, "single answer not marked last")

	// Clear always leaves the stack empty
	`VLRS_ASSERT_NOW(a_clear_empty, clk, arst_n, out_valid && status == ST_CLEARED,
		is_empty && !byte_valid, "clear did not empty the stack")

endmodule

bind variable_length_record_stack vlrs_checker u_vlrs_checker (.*);

`default_nettype wire
